@@ design/rsi_pkg.sv @@
// Shared payload types and fixed widths for the ray/sphere intersection pipeline.
package rsi_pkg;

	// One ray/sphere pair per transfer, all Q16.16; the radius field is unsigned.
	typedef struct packed {
		logic signed [31:0] ray_origin_x;
		logic signed [31:0] ray_origin_y;
		logic signed [31:0] ray_origin_z;
		logic signed [31:0] ray_dir_x;
		logic signed [31:0] ray_dir_y;
		logic signed [31:0] ray_dir_z;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic        [30:0] radius;
	} rsi_in_t;

	// One result per transfer.
	typedef struct packed {
		logic        hit;
		logic [30:0] hit_distance;
	} rsi_out_t;

	// Multiplier slice width (one partial product per pipeline stage).
	localparam int SliceW = 17;

	// Internal widths, all two's complement unless noted.
	localparam int OcW   = 33;              // origin minus center
	localparam int AW    = 66;              // a = d.d
	localparam int HW    = 67;              // h = oc.d
	localparam int CW    = 68;              // c = oc.oc - r*r
	localparam int DW    = 135;             // discriminant h*h - a*c
	localparam int RootW = 66;              // floor(sqrt(discriminant)), unsigned
	localparam int NW    = 69;              // -h -/+ root
	localparam int XW    = 84;              // numerator scaled by 2^16, unsigned
	localparam int QW    = 31;              // quotient bits
	localparam int DvW   = AW + QW;         // divisor trial width
	localparam int FracBits = 16;

	localparam logic [15:0] MinDistReset = 16'd66;

endpackage

@@ design/rsi_mul.sv @@
// Pipelined signed multiplier: sign-magnitude, one operand slice per stage.
module rsi_mul import rsi_pkg::*; #(
	parameter int WA  = 33,
	parameter int WB  = 32,
	parameter int NSL = 2
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	localparam int NBW = NSL * SliceW;
	localparam int PW  = WA + NBW;

	logic [WA-1:0]    a_abs;
	logic [WB-1:0]    b_abs;
	logic [WA-1:0]    ma_q  [0:NSL];
	logic [NBW-1:0]   mb_q  [0:NSL];
	logic             sg_q  [0:NSL];
	logic [PW-1:0]    acc_q [0:NSL];
	logic [WA+WB-1:0] mag;

	// Operand magnitudes; the most negative value maps to its unsigned magnitude.
	assign a_abs = a[WA-1] ? WA'(-a) : WA'(a);
	assign b_abs = b[WB-1] ? WB'(-b) : WB'(b);

	// Input register.
	always_ff @(posedge clk) begin
		if (en) begin
			ma_q[0]  <= a_abs;
			mb_q[0]  <= NBW'(b_abs);
			sg_q[0]  <= a[WA-1] ^ b[WB-1];
			acc_q[0] <= '0;
		end
	end

	// One partial product added per stage.
	for (genvar k = 0; k < NSL; k++) begin : g_stage
		logic [WA+SliceW-1:0] pp;

		assign pp = ma_q[k] * mb_q[k][k*SliceW +: SliceW];

		always_ff @(posedge clk) begin
			if (en) begin
				ma_q[k+1]  <= ma_q[k];
				mb_q[k+1]  <= mb_q[k];
				sg_q[k+1]  <= sg_q[k];
				acc_q[k+1] <= acc_q[k] + (PW'(pp) << (k * SliceW));
			end
		end
	end

	// Restore the sign.
	assign mag = acc_q[NSL][WA+WB-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			p <= sg_q[NSL] ? -mag : mag;
		end
	end

endmodule

@@ design/rsi_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module rsi_sqrt import rsi_pkg::*; #(
	parameter int WR = 66
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*WR-1:0] d,
	output logic [WR-1:0]   root
);

	localparam int TW = 2 * WR + 1;

	logic [2*WR-1:0] rem_w [0:WR];
	logic [WR-1:0]   q_w   [0:WR];
	logic [2*WR-1:0] rem_q [0:WR-1];
	logic [WR-1:0]   q_q   [0:WR-1];

	assign rem_w[0] = d;
	assign q_w[0]   = '0;

	// Stage i decides bit WR-1-i: keep it if (q + 2^k)^2 still fits under the input.
	for (genvar i = 0; i < WR; i++) begin : g_stage
		localparam int K = WR - 1 - i;
		logic [TW-1:0] trial;
		logic          ge;

		assign trial = (TW'(q_w[i]) << (K + 1)) | (TW'(1) << (2 * K));
		assign ge    = TW'(rem_w[i]) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? rem_w[i] - trial[2*WR-1:0] : rem_w[i];
				q_q[i]   <= ge ? (q_w[i] | (WR'(1) << K)) : q_w[i];
			end
		end

		assign rem_w[i+1] = rem_q[i];
		assign q_w[i+1]   = q_q[i];
	end

	assign root = q_w[WR];

endmodule

@@ design/ray_sphere_intersect.sv @@
// Top level of the fixed-point ray/sphere intersection pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one ray and one sphere
//   per transfer. Output channel (out_valid / out_stall / out_data) returns one
//   result per input: hit and the nearest root above min_distance in Q16.16,
//   saturated, or zero when there is no hit.
//   The epsilon register is written through cfg_we / cfg_wdata; the user must
//   do so only while idle, which the block does not enforce.
// Timing:
//   A new item is taken every cycle unless a stall holds the pipeline.
//   The depth is set by the 66-stage square root, one root bit per stage, and
//   the 31-stage quotient, one quotient bit per stage; the multipliers are sliced.
// Reset:
//   arst_n clears all valid bits and loads min_distance with 66.
// Stall:
//   While a result sits in the output register and out_stall is high, the whole
//   pipeline holds and in_stall is raised; nothing is lost or repeated.
module ray_sphere_intersect import rsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  rsi_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsi_out_t    out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int M1Nsl = 2;
	localparam int M1Lat = M1Nsl + 2;
	localparam int M2Nsl = 4;
	localparam int M2Lat = M2Nsl + 2;

	logic adv;
	logic [15:0] min_distance_q;

	// Stage 1 registers.
	logic                  v_s1;
	logic signed [OcW-1:0] oc_s1 [0:2];
	logic signed [31:0]    d_s1  [0:2];
	logic signed [31:0]    r_s1;

	// First product group.
	logic signed [63:0]    dd_p [0:2];
	logic signed [64:0]    od_p [0:2];
	logic signed [65:0]    oo_p [0:2];
	logic signed [63:0]    rr_p;
	logic [M1Lat-1:0]      v_m1_q;

	// Stage 2 registers.
	logic                  v_s2;
	logic signed [AW-1:0]  a_s2;
	logic signed [HW-1:0]  h_s2;
	logic signed [CW-1:0]  c_s2;

	// Second product group.
	logic signed [2*HW-1:0]  hh_p;
	logic signed [CW+AW-1:0] ac_p;
	logic [M2Lat-1:0]        v_m2_q;
	logic signed [AW-1:0]    a_m2_q [0:M2Lat-1];
	logic signed [HW-1:0]    h_m2_q [0:M2Lat-1];

	// Stage 3 registers.
	logic signed [DW-1:0]  d_c;
	logic                  v_s3;
	logic                  kill_s3;
	logic signed [DW-1:0]  d_s3;
	logic signed [AW-1:0]  a_s3;
	logic signed [HW-1:0]  h_s3;
	logic [2*RootW-1:0]    sq_in;

	// Square root and its side data.
	logic [RootW-1:0]      root;
	logic [RootW-1:0]      v_sq_q;
	logic                  kill_sq_q [0:RootW-1];
	logic signed [AW-1:0]  a_sq_q    [0:RootW-1];
	logic signed [HW-1:0]  h_sq_q    [0:RootW-1];

	// Stage 4 registers.
	logic signed [NW-1:0]  n1;
	logic signed [NW-1:0]  n2;
	logic                  pos1;
	logic                  pos2;
	logic                  v_s4;
	logic                  p1_s4;
	logic                  p2_s4;
	logic [XW-1:0]         x1_s4;
	logic [XW-1:0]         x2_s4;
	logic [AW-1:0]         a_s4;

	// Divider stages.
	logic [XW-1:0] rem1_w [0:QW];
	logic [XW-1:0] rem2_w [0:QW];
	logic [QW-1:0] q1_w   [0:QW];
	logic [QW-1:0] q2_w   [0:QW];
	logic [AW-1:0] ad_w   [0:QW];
	logic          p1_w   [0:QW];
	logic          p2_w   [0:QW];
	logic          vd_w   [0:QW];
	logic [XW-1:0] rem1_q [0:QW-1];
	logic [XW-1:0] rem2_q [0:QW-1];
	logic [QW-1:0] q1_q   [0:QW-1];
	logic [QW-1:0] q2_q   [0:QW-1];
	logic [AW-1:0] ad_q   [0:QW-1];
	logic          p1_q   [0:QW-1];
	logic          p2_q   [0:QW-1];
	logic [QW-1:0] vd_q;

	// Output stage.
	logic     ok1;
	logic     ok2;
	logic     out_valid_q;
	rsi_out_t out_data_q;

	// The whole pipeline moves unless a finished result is held by the receiver.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// Epsilon register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_distance_q <= MinDistReset;
		end else if (cfg_we) begin
			min_distance_q <= cfg_wdata;
		end
	end

	// Stage 1: offset from the sphere center.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oc_s1[0] <= OcW'(in_data.ray_origin_x) - OcW'(in_data.center_x);
			oc_s1[1] <= OcW'(in_data.ray_origin_y) - OcW'(in_data.center_y);
			oc_s1[2] <= OcW'(in_data.ray_origin_z) - OcW'(in_data.center_z);
			d_s1[0]  <= in_data.ray_dir_x;
			d_s1[1]  <= in_data.ray_dir_y;
			d_s1[2]  <= in_data.ray_dir_z;
			r_s1     <= {1'b0, in_data.radius};
		end
	end

	// First product group: the dot-product terms and the radius square.
	for (genvar i = 0; i < 3; i++) begin : g_dot
		rsi_mul #(.WA(32), .WB(32), .NSL(M1Nsl)) u_dd (
			.clk(clk), .en(adv), .a(d_s1[i]), .b(d_s1[i]), .p(dd_p[i])
		);
		rsi_mul #(.WA(OcW), .WB(32), .NSL(M1Nsl)) u_od (
			.clk(clk), .en(adv), .a(oc_s1[i]), .b(d_s1[i]), .p(od_p[i])
		);
		rsi_mul #(.WA(OcW), .WB(OcW), .NSL(M1Nsl)) u_oo (
			.clk(clk), .en(adv), .a(oc_s1[i]), .b(oc_s1[i]), .p(oo_p[i])
		);
	end

	rsi_mul #(.WA(32), .WB(32), .NSL(M1Nsl)) u_rr (
		.clk(clk), .en(adv), .a(r_s1), .b(r_s1), .p(rr_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1_q <= '0;
		end else if (adv) begin
			v_m1_q <= {v_m1_q[M1Lat-2:0], v_s1};
		end
	end

	// Stage 2: sum the terms into a, h and c.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_m1_q[M1Lat-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= AW'(dd_p[0]) + AW'(dd_p[1]) + AW'(dd_p[2]);
			h_s2 <= HW'(od_p[0]) + HW'(od_p[1]) + HW'(od_p[2]);
			c_s2 <= CW'(oo_p[0]) + CW'(oo_p[1]) + CW'(oo_p[2]) - CW'(rr_p);
		end
	end

	// Second product group: h*h and a*c.
	rsi_mul #(.WA(HW), .WB(HW), .NSL(M2Nsl)) u_hh (
		.clk(clk), .en(adv), .a(h_s2), .b(h_s2), .p(hh_p)
	);
	rsi_mul #(.WA(CW), .WB(AW), .NSL(M2Nsl)) u_ac (
		.clk(clk), .en(adv), .a(c_s2), .b(a_s2), .p(ac_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m2_q <= '0;
		end else if (adv) begin
			v_m2_q <= {v_m2_q[M2Lat-2:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_m2_q[0] <= a_s2;
			h_m2_q[0] <= h_s2;
			for (int i = 1; i < M2Lat; i++) begin
				a_m2_q[i] <= a_m2_q[i-1];
				h_m2_q[i] <= h_m2_q[i-1];
			end
		end
	end

	// Stage 3: discriminant, and the cases with no hit at all.
	assign d_c = DW'(hh_p) - DW'(ac_p);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_m2_q[M2Lat-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3    <= d_c;
			kill_s3 <= (a_m2_q[M2Lat-1] == '0) || d_c[DW-1];
			a_s3    <= a_m2_q[M2Lat-1];
			h_s3    <= h_m2_q[M2Lat-1];
		end
	end

	assign sq_in = kill_s3 ? '0 : d_s3[2*RootW-1:0];

	// Square root with its side data carried alongside.
	rsi_sqrt #(.WR(RootW)) u_sqrt (
		.clk(clk), .en(adv), .d(sq_in), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq_q <= '0;
		end else if (adv) begin
			v_sq_q <= {v_sq_q[RootW-2:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kill_sq_q[0] <= kill_s3;
			a_sq_q[0]    <= a_s3;
			h_sq_q[0]    <= h_s3;
			for (int i = 1; i < RootW; i++) begin
				kill_sq_q[i] <= kill_sq_q[i-1];
				a_sq_q[i]    <= a_sq_q[i-1];
				h_sq_q[i]    <= h_sq_q[i-1];
			end
		end
	end

	// Stage 4: root numerators, scaled by 2^16 when positive for a Q16.16 quotient.
	assign n1   = -NW'(h_sq_q[RootW-1]) - NW'(root);
	assign n2   = -NW'(h_sq_q[RootW-1]) + NW'(root);
	assign pos1 = !n1[NW-1] && (n1 != '0);
	assign pos2 = !n2[NW-1] && (n2 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_sq_q[RootW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s4 <= pos1 && !kill_sq_q[RootW-1];
			p2_s4 <= pos2 && !kill_sq_q[RootW-1];
			x1_s4 <= pos1 ? (XW'(n1) << FracBits) : '0;
			x2_s4 <= pos2 ? (XW'(n2) << FracBits) : '0;
			a_s4  <= AW'(a_sq_q[RootW-1]);
		end
	end

	// Two restoring dividers side by side, one quotient bit per stage.
	// Keeping every bit while the remainder stays large gives the saturated value.
	assign rem1_w[0] = x1_s4;
	assign rem2_w[0] = x2_s4;
	assign q1_w[0]   = '0;
	assign q2_w[0]   = '0;
	assign ad_w[0]   = a_s4;
	assign p1_w[0]   = p1_s4;
	assign p2_w[0]   = p2_s4;
	assign vd_w[0]   = v_s4;

	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int K = QW - 1 - i;
		logic [DvW-1:0] trial;
		logic           ge1;
		logic           ge2;

		assign trial = DvW'(ad_w[i]) << K;
		assign ge1   = DvW'(rem1_w[i]) >= trial;
		assign ge2   = DvW'(rem2_w[i]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_q[i] <= 1'b0;
			end else if (adv) begin
				vd_q[i] <= vd_w[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem1_q[i] <= ge1 ? rem1_w[i] - trial[XW-1:0] : rem1_w[i];
				rem2_q[i] <= ge2 ? rem2_w[i] - trial[XW-1:0] : rem2_w[i];
				q1_q[i]   <= ge1 ? (q1_w[i] | (QW'(1) << K)) : q1_w[i];
				q2_q[i]   <= ge2 ? (q2_w[i] | (QW'(1) << K)) : q2_w[i];
				ad_q[i]   <= ad_w[i];
				p1_q[i]   <= p1_w[i];
				p2_q[i]   <= p2_w[i];
			end
		end

		assign rem1_w[i+1] = rem1_q[i];
		assign rem2_w[i+1] = rem2_q[i];
		assign q1_w[i+1]   = q1_q[i];
		assign q2_w[i+1]   = q2_q[i];
		assign ad_w[i+1]   = ad_q[i];
		assign p1_w[i+1]   = p1_q[i];
		assign p2_w[i+1]   = p2_q[i];
		assign vd_w[i+1]   = vd_q[i];
	end

	// Output stage: nearer root first, each checked against the epsilon.
	assign ok1 = p1_w[QW] && (q1_w[QW] > QW'(min_distance_q));
	assign ok2 = p2_w[QW] && (q2_w[QW] > QW'(min_distance_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vd_w[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.hit          <= ok1 || ok2;
			out_data_q.hit_distance <= ok1 ? q1_w[QW] : (ok2 ? q2_w[QW] : '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ design/rsi_checker.sv @@
// Port-level checks for the intersection pipeline, bound to the top level.
module rsi_checker import rsi_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input rsi_out_t out_data
);

	// A result without a hit always reports zero distance.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.hit_distance == '0)
		else $error("miss with nonzero distance");

	// A held result stays put until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The input only stalls behind a held result.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no held result");

	// A cycle in reset leaves the output empty on the next cycle.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result during reset");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
